>>> design/rrwl_pkg.sv
// Shared types and codes for the recursive reader/writer lock table.
package rrwl_pkg;

  localparam logic [1:0] ACT_EXCL_LOCK   = 2'd0;
  localparam logic [1:0] ACT_EXCL_UNLOCK = 2'd1;
  localparam logic [1:0] ACT_SH_LOCK     = 2'd2;
  localparam logic [1:0] ACT_SH_UNLOCK   = 2'd3;

  localparam logic [2:0] STAT_GRANTED  = 3'd0;
  localparam logic [2:0] STAT_BUSY     = 3'd1;
  localparam logic [2:0] STAT_NOT_HELD = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_UPD  = 3'b100
  } state_t;

endpackage

>>> design/rrwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/recursive_reader_writer_lock_table_top.sv
// Top level of the recursive reader/writer lock table.
//
// Usage:
//   in_*  : one lock request per transfer. in_tdata = {requester, action}.
//   out_* : one answer per request, in request order:
//           out_tdata = {reader_entries, writer_held, status}.
//   Exclusive requests go from S_IDLE to S_UPD, which writes the result register;
//   the next request is accepted once the block is back in S_IDLE.
//   Shared requests scan the reader table in a RAM, one slot per cycle, and
//   pass through S_IDLE, S_SCAN and S_UPD before they reach the result register;
//   the scan through the single RAM read port sets how long such a request takes.
//   Only one request is in flight; in_tready is high while no request is
//   being worked on, also while a finished answer still waits in the output
//   register. A receiver stall holds the answer there and holds the next
//   request in its final step until the output register frees up.
//   Reset (rst_n low, synchronous) clears the owner, both owner depths, all
//   reader valid bits and the output valid; no clearing pass is needed.
module recursive_reader_writer_lock_table_top #(
  parameter int READER_SLOTS = 16,
  parameter int ID_BITS      = 8,
  parameter int DEPTH_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] action, [9:2] requester, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] status, [3] writer_held, [8:4] reader_entries
);

  localparam int SLOT_BITS = $clog2(READER_SLOTS);
  localparam int CNT_BITS  = $clog2(READER_SLOTS + 1);
  localparam int ENT_BITS  = ID_BITS + DEPTH_BITS;
  localparam int REQ_WIDE  = (ID_BITS > 8) ? ID_BITS : 8;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  rrwl_pkg::state_t state_r, state_nxt;

  logic [1:0]              act_r, act_nxt;
  logic [ID_BITS-1:0]      req_r, req_nxt;
  logic [ID_BITS-1:0]      req_in;
  logic [REQ_WIDE-1:0]     req_wide;

  logic [ID_BITS-1:0]      owner_id_r, owner_id_nxt;
  logic                    owner_valid_r, owner_valid_nxt;
  logic [DEPTH_BITS-1:0]   wd_r, wd_nxt;
  logic [DEPTH_BITS-1:0]   siw_r, siw_nxt;
  logic [READER_SLOTS-1:0] valid_r, valid_nxt;
  logic [CNT_BITS-1:0]     rd_count_r, rd_count_nxt;

  logic [CNT_BITS-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [SLOT_BITS-1:0]    chk_idx_r, chk_idx_nxt;
  logic                    found_r, found_nxt;
  logic [SLOT_BITS-1:0]    hit_idx_r, hit_idx_nxt;
  logic [DEPTH_BITS-1:0]   hit_depth_r, hit_depth_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [SLOT_BITS-1:0]    free_idx_r, free_idx_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [2:0]              out_status_r, out_status_nxt;
  logic                    out_held_r, out_held_nxt;
  logic [4:0]              out_entries_r, out_entries_nxt;

  logic                    ram_we, ram_re;
  logic [SLOT_BITS-1:0]    ram_waddr;
  logic [ENT_BITS-1:0]     ram_wdata, ram_rdata;
  logic [ID_BITS-1:0]      ram_id;
  logic [DEPTH_BITS-1:0]   ram_depth;

  logic                    can_out, is_owner, is_shared_in, owner_free;
  logic [DEPTH_BITS-1:0]   op_a, op_res;
  logic                    op_dec, op_max, op_zero, op_one;
  logic [2:0]              status;

  assign req_wide  = REQ_WIDE'(in_tdata[9:2]);
  assign req_in    = req_wide[ID_BITS-1:0];
  assign ram_id    = ram_rdata[ENT_BITS-1:DEPTH_BITS];
  assign ram_depth = ram_rdata[DEPTH_BITS-1:0];

  assign in_tready  = (state_r == rrwl_pkg::S_IDLE);
  assign can_out    = !out_valid_r || out_tready;
  assign is_owner   = owner_valid_r && (owner_id_r == req_r);
  assign owner_free = !owner_valid_r && (wd_r == '0) && (siw_r == '0);
  assign is_shared_in = (in_tdata[1:0] == rrwl_pkg::ACT_SH_LOCK) ||
                        (in_tdata[1:0] == rrwl_pkg::ACT_SH_UNLOCK);
  assign ram_re     = (state_r == rrwl_pkg::S_SCAN) &&
                      (scan_cnt_r < CNT_BITS'(READER_SLOTS));

  // shared depth unit: one increment/decrement and compare
  always_comb begin
    if ((act_r == rrwl_pkg::ACT_EXCL_LOCK) || (act_r == rrwl_pkg::ACT_EXCL_UNLOCK)) begin
      op_a = wd_r;
    end else if (is_owner) begin
      op_a = siw_r;
    end else begin
      op_a = hit_depth_r;
    end
    op_dec  = (act_r == rrwl_pkg::ACT_EXCL_UNLOCK) || (act_r == rrwl_pkg::ACT_SH_UNLOCK);
    op_res  = op_dec ? (op_a - DEPTH_ONE) : (op_a + DEPTH_ONE);
    op_max  = (op_a == DEPTH_MAX);
    op_zero = (op_a == '0);
    op_one  = (op_a == DEPTH_ONE);
  end

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    req_nxt         = req_r;
    owner_id_nxt    = owner_id_r;
    owner_valid_nxt = owner_valid_r;
    wd_nxt          = wd_r;
    siw_nxt         = siw_r;
    valid_nxt       = valid_r;
    rd_count_nxt    = rd_count_r;
    scan_cnt_nxt    = scan_cnt_r;
    chk_vld_nxt     = 1'b0;
    chk_idx_nxt     = chk_idx_r;
    found_nxt       = found_r;
    hit_idx_nxt     = hit_idx_r;
    hit_depth_nxt   = hit_depth_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_held_nxt    = out_held_r;
    out_entries_nxt = out_entries_r;
    ram_we          = 1'b0;
    ram_waddr       = hit_idx_r;
    ram_wdata       = {req_r, op_res};
    status          = rrwl_pkg::STAT_GRANTED;

    case (state_r)
      rrwl_pkg::S_IDLE: begin
        if (in_tvalid) begin
          act_nxt        = in_tdata[1:0];
          req_nxt        = req_in;
          scan_cnt_nxt   = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = is_shared_in ? rrwl_pkg::S_SCAN : rrwl_pkg::S_UPD;
        end
      end
      rrwl_pkg::S_SCAN: begin
        if (ram_re) begin
          scan_cnt_nxt = scan_cnt_r + CNT_BITS'(1);
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_cnt_r[SLOT_BITS-1:0];
        end
        if (chk_vld_r) begin
          if (valid_r[chk_idx_r] && (ram_id == req_r) && !found_r) begin
            found_nxt     = 1'b1;
            hit_idx_nxt   = chk_idx_r;
            hit_depth_nxt = ram_depth;
          end
          if (!valid_r[chk_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          if (!ram_re) begin
            state_nxt = rrwl_pkg::S_UPD;
          end
        end
      end
      rrwl_pkg::S_UPD: begin
        if (can_out) begin
          case (act_r)
            rrwl_pkg::ACT_EXCL_LOCK: begin
              if (is_owner) begin
                if (op_max) status = rrwl_pkg::STAT_OVERFLOW;
                else        wd_nxt = op_res;
              end else if (owner_free && (rd_count_r == '0)) begin
                owner_id_nxt    = req_r;
                owner_valid_nxt = 1'b1;
                wd_nxt          = DEPTH_ONE;
              end else begin
                status = rrwl_pkg::STAT_BUSY;
              end
            end
            rrwl_pkg::ACT_EXCL_UNLOCK: begin
              if (!is_owner || op_zero) begin
                status = rrwl_pkg::STAT_NOT_HELD;
              end else begin
                wd_nxt = op_res;
                if (op_one && (siw_r == '0)) begin
                  owner_valid_nxt = 1'b0;
                  owner_id_nxt    = '0;
                end
              end
            end
            rrwl_pkg::ACT_SH_LOCK: begin
              if (is_owner) begin
                if (op_max) status  = rrwl_pkg::STAT_OVERFLOW;
                else        siw_nxt = op_res;
              end else if (found_r) begin
                if (op_max) begin
                  status = rrwl_pkg::STAT_OVERFLOW;
                end else begin
                  ram_we = 1'b1;
                end
              end else if (owner_free) begin
                if (!free_found_r) begin
                  status = rrwl_pkg::STAT_FULL;
                end else begin
                  ram_we                = 1'b1;
                  ram_waddr             = free_idx_r;
                  ram_wdata             = {req_r, DEPTH_ONE};
                  valid_nxt[free_idx_r] = 1'b1;
                  rd_count_nxt          = rd_count_r + CNT_BITS'(1);
                end
              end else begin
                status = rrwl_pkg::STAT_BUSY;
              end
            end
            rrwl_pkg::ACT_SH_UNLOCK: begin
              if (is_owner) begin
                if (op_zero) begin
                  status = rrwl_pkg::STAT_NOT_HELD;
                end else begin
                  siw_nxt = op_res;
                  if (op_one && (wd_r == '0)) begin
                    owner_valid_nxt = 1'b0;
                    owner_id_nxt    = '0;
                  end
                end
              end else if (found_r) begin
                if (op_zero || op_one) begin
                  valid_nxt[hit_idx_r] = 1'b0;
                  rd_count_nxt         = rd_count_r - CNT_BITS'(1);
                end else begin
                  ram_we = 1'b1;
                end
              end else begin
                status = rrwl_pkg::STAT_NOT_HELD;
              end
            end
            default: begin
              status = rrwl_pkg::STAT_NOT_HELD;
            end
          endcase
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status;
          out_held_nxt    = owner_valid_nxt;
          out_entries_nxt = 5'(rd_count_nxt);
          state_nxt       = rrwl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrwl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rrwl_pkg::S_IDLE;
      owner_id_r    <= '0;
      owner_valid_r <= 1'b0;
      wd_r          <= '0;
      siw_r         <= '0;
      valid_r       <= '0;
      rd_count_r    <= '0;
      chk_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      owner_id_r    <= owner_id_nxt;
      owner_valid_r <= owner_valid_nxt;
      wd_r          <= wd_nxt;
      siw_r         <= siw_nxt;
      valid_r       <= valid_nxt;
      rd_count_r    <= rd_count_nxt;
      chk_vld_r     <= chk_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    req_r         <= req_nxt;
    scan_cnt_r    <= scan_cnt_nxt;
    chk_idx_r     <= chk_idx_nxt;
    found_r       <= found_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_depth_r   <= hit_depth_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_held_r    <= out_held_nxt;
    out_entries_r <= out_entries_nxt;
  end

  rrwl_ram #(
    .WIDTH (ENT_BITS),
    .DEPTH (READER_SLOTS)
  ) u_reader_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_cnt_r[SLOT_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_entries_r, out_held_r, out_status_r};

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    rd_count_r == CNT_BITS'($countones(valid_r)))
    else $error("reader count out of step with valid bits");

  a_owner_depths: assert property (@(posedge clk) disable iff (!rst_n)
    owner_valid_r == ((wd_r != '0) || (siw_r != '0)))
    else $error("owner flag out of step with owner depths");

  a_owner_excludes_readers: assert property (@(posedge clk) disable iff (!rst_n)
    owner_valid_r |-> (rd_count_r == '0))
    else $error("exclusive owner coexists with readers");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrwl_pkg::S_SCAN) |-> (scan_cnt_r <= CNT_BITS'(READER_SLOTS)))
    else $error("scan counter ran past the table");

endmodule
